// ----- sv/tdp_pkg.sv -----
// Shared widths, records and the division-step helper for the triangle depth pipeline.
package tdp_pkg;

  localparam int CoordW = 16;
  localparam int DepthW = 32;
  localparam int FracB  = 24;
  localparam int RowW   = CoordW + 1;
  localparam int ColW   = CoordW + FracB + 2;
  localparam int FracW  = FracB + 1;
  localparam int ProdW  = DepthW + 1 + FracW + 1;
  localparam int DivBits = 4;
  localparam int DivStages = FracB / DivBits;

  localparam logic [FracW-1:0] FracOne = FracW'(1) << FracB;
  localparam logic signed [DepthW-1:0] DepthFar = {1'b0, {(DepthW-1){1'b1}}};

  typedef struct packed {
    logic signed [CoordW-1:0] r;
    logic signed [CoordW-1:0] c;
    logic signed [DepthW-1:0] d;
  } vtx_t;

  typedef struct packed {
    logic [ColW:0]    rem;
    logic [FracB-1:0] q;
  } div_t;

  // DivBits steps of restoring division; the remainder stays below den whenever it starts below den.
  function automatic div_t div_step(div_t x, logic [ColW:0] den);
    div_t y;
    logic [ColW:0] r;
    y = x;
    for (int i = 0; i < DivBits; i++) begin
      r = {y.rem[ColW-1:0], 1'b0};
      if (r >= den) begin
        y.rem = r - den;
        y.q   = {y.q[FracB-2:0], 1'b1};
      end else begin
        y.rem = r;
        y.q   = {y.q[FracB-2:0], 1'b0};
      end
    end
    return y;
  endfunction

endpackage

// ----- sv/tdp_in_if.sv -----
// Input channel: triangle vertices and the sample point of one word.
interface tdp_in_if;
  logic valid;
  logic ready;
  logic signed [tdp_pkg::CoordW-1:0] vertex_a_row;
  logic signed [tdp_pkg::CoordW-1:0] vertex_a_col;
  logic signed [tdp_pkg::DepthW-1:0] vertex_a_depth;
  logic signed [tdp_pkg::CoordW-1:0] vertex_b_row;
  logic signed [tdp_pkg::CoordW-1:0] vertex_b_col;
  logic signed [tdp_pkg::DepthW-1:0] vertex_b_depth;
  logic signed [tdp_pkg::CoordW-1:0] vertex_c_row;
  logic signed [tdp_pkg::CoordW-1:0] vertex_c_col;
  logic signed [tdp_pkg::DepthW-1:0] vertex_c_depth;
  logic signed [tdp_pkg::CoordW-1:0] sample_row;
  logic signed [tdp_pkg::CoordW-1:0] sample_col;

  modport source (output valid, vertex_a_row, vertex_a_col, vertex_a_depth,
                  vertex_b_row, vertex_b_col, vertex_b_depth, vertex_c_row,
                  vertex_c_col, vertex_c_depth, sample_row, sample_col,
                  input ready);
  modport sink (input valid, vertex_a_row, vertex_a_col, vertex_a_depth,
                vertex_b_row, vertex_b_col, vertex_b_depth, vertex_c_row,
                vertex_c_col, vertex_c_depth, sample_row, sample_col,
                output ready);
endinterface

// ----- sv/tdp_out_if.sv -----
// Output channel: coverage flag and depth of one word.
interface tdp_out_if;
  logic valid;
  logic ready;
  logic covered;
  logic signed [tdp_pkg::DepthW-1:0] point_depth;

  modport source (output valid, covered, point_depth, input ready);
  modport sink (input valid, covered, point_depth, output ready);
endinterface

// ----- sv/triangle_depth_at_point.sv -----
// Depth of a triangle at one sample point; each accepted word passes every stage register.
// Throughput is one word per cycle unless the output stalls; the whole 17-stage pipeline
// advances together and holds as one while the output word waits, so nothing is lost
// or repeated on a stall. Depth is set by two 24-bit division rounds, four quotient bits a stage.
// Synchronous active-high reset clears only the stage valid bits; data is not reset.
module triangle_depth_at_point (
  input  logic      clk,
  input  logic      rst,
  tdp_in_if.sink    req,
  tdp_out_if.source rsp
);

  localparam int NumSt  = 2 * tdp_pkg::DivStages + 5;
  localparam int DivA0  = 1;
  localparam int ColSt  = DivA0 + tdp_pkg::DivStages;
  localparam int SpanSt = ColSt + 1;
  localparam int DivB0  = SpanSt + 1;
  localparam int MulSt  = DivB0 + tdp_pkg::DivStages;
  localparam int OutSt  = MulSt + 1;

  // One record carries everything an item needs down the pipe; each stage fills
  // in its own fields and passes the rest along untouched.
  typedef struct packed {
    logic v;
    logic rows_ok;
    logic cov;
    logic sat;
    tdp_pkg::vtx_t top;
    tdp_pkg::vtx_t bot;
    tdp_pkg::vtx_t st;
    tdp_pkg::vtx_t sb;
    logic signed [tdp_pkg::CoordW-1:0] col;
    logic [tdp_pkg::ColW:0] den_l;
    logic [tdp_pkg::ColW:0] den_s;
    logic [tdp_pkg::ColW:0] den_x;
    tdp_pkg::div_t div_l;
    tdp_pkg::div_t div_s;
    tdp_pkg::div_t div_x;
    logic signed [tdp_pkg::ColW-1:0] lc;
    logic signed [tdp_pkg::ColW-1:0] sc;
    logic signed [tdp_pkg::ColW-1:0] s;
    logic signed [tdp_pkg::DepthW-1:0] dl;
    logic signed [tdp_pkg::DepthW-1:0] ds;
    logic signed [tdp_pkg::ProdW-1:0] prod;
  } stage_t;

  stage_t pipe [NumSt];
  stage_t pipe_next [NumSt];
  logic   adv;

  // The pipe moves whenever the output register is empty or being emptied.
  assign adv       = !pipe[OutSt].v || rsp.ready;
  assign req.ready = adv;

  // Stage 0: sort by row (ties keep a, b, c order), pick the short edge and
  // form the row numerators and denominators for both edge fractions.
  always_comb begin
    tdp_pkg::vtx_t a, b, c, top, mid, bot, st, sb;
    logic signed [tdp_pkg::CoordW-1:0] row;
    a = '{req.vertex_a_row, req.vertex_a_col, req.vertex_a_depth};
    b = '{req.vertex_b_row, req.vertex_b_col, req.vertex_b_depth};
    c = '{req.vertex_c_row, req.vertex_c_col, req.vertex_c_depth};
    row = req.sample_row;
    if (a.r <= b.r) begin
      if (b.r <= c.r) begin
        top = a; mid = b; bot = c;
      end else if (a.r <= c.r) begin
        top = a; mid = c; bot = b;
      end else begin
        top = c; mid = a; bot = b;
      end
    end else if (a.r <= c.r) begin
      top = b; mid = a; bot = c;
    end else if (b.r <= c.r) begin
      top = b; mid = c; bot = a;
    end else begin
      top = c; mid = b; bot = a;
    end
    // The upper short edge is taken only strictly above the middle row, which
    // keeps a flat-topped triangle clear of a zero-length edge.
    if (row < mid.r) begin
      st = top; sb = mid;
    end else begin
      st = mid; sb = bot;
    end
    pipe_next[0]         = pipe[0];
    pipe_next[0].v       = req.valid;
    pipe_next[0].rows_ok = (row >= top.r) && (row < bot.r);
    pipe_next[0].cov     = 1'b0;
    pipe_next[0].sat     = 1'b0;
    pipe_next[0].top     = top;
    pipe_next[0].bot     = bot;
    pipe_next[0].st      = st;
    pipe_next[0].sb      = sb;
    pipe_next[0].col     = req.sample_col;
    pipe_next[0].div_l.rem = (tdp_pkg::ColW+1)'(unsigned'(tdp_pkg::RowW'(
                               tdp_pkg::RowW'(row) - tdp_pkg::RowW'(top.r))));
    pipe_next[0].den_l     = (tdp_pkg::ColW+1)'(unsigned'(tdp_pkg::RowW'(
                               tdp_pkg::RowW'(bot.r) - tdp_pkg::RowW'(top.r))));
    pipe_next[0].div_s.rem = (tdp_pkg::ColW+1)'(unsigned'(tdp_pkg::RowW'(
                               tdp_pkg::RowW'(row) - tdp_pkg::RowW'(st.r))));
    pipe_next[0].den_s     = (tdp_pkg::ColW+1)'(unsigned'(tdp_pkg::RowW'(
                               tdp_pkg::RowW'(sb.r) - tdp_pkg::RowW'(st.r))));
    pipe_next[0].div_l.q = '0;
    pipe_next[0].div_s.q = '0;
  end

  for (genvar k = 1; k < NumSt; k++) begin : g_stage
    always_comb begin
      stage_t p, n;
      logic signed [tdp_pkg::RowW-1:0] dcl, dcs;
      logic signed [tdp_pkg::ColW-1:0] lo, hi;
      logic signed [tdp_pkg::DepthW:0] ddl, dds, ddx;
      logic signed [tdp_pkg::ProdW-1:0] pl, ps;
      logic [tdp_pkg::FracW-1:0] fx;
      logic signed [tdp_pkg::ProdW-1:0] sum;
      p = pipe[k-1];
      n = p;
      if (k < ColSt) begin
        // Edge fractions along the rows, four quotient bits a stage.
        n.div_l = tdp_pkg::div_step(p.div_l, p.den_l);
        n.div_s = tdp_pkg::div_step(p.div_s, p.den_s);
      end else if (k == ColSt) begin
        // Edge columns at the sample row, with 24 extra fraction bits.
        dcl  = tdp_pkg::RowW'(p.bot.c) - tdp_pkg::RowW'(p.top.c);
        dcs  = tdp_pkg::RowW'(p.sb.c) - tdp_pkg::RowW'(p.st.c);
        n.lc = (tdp_pkg::ColW'(p.top.c) <<< tdp_pkg::FracB)
             + tdp_pkg::ColW'(dcl * signed'({1'b0, p.div_l.q}));
        n.sc = (tdp_pkg::ColW'(p.st.c) <<< tdp_pkg::FracB)
             + tdp_pkg::ColW'(dcs * signed'({1'b0, p.div_s.q}));
        n.s  = tdp_pkg::ColW'(p.col) <<< tdp_pkg::FracB;
      end else if (k == SpanSt) begin
        // Half-open span test, span fraction operands and both edge depths.
        lo = (p.lc <= p.sc) ? p.lc : p.sc;
        hi = (p.lc <= p.sc) ? p.sc : p.lc;
        n.cov = p.rows_ok && (p.s >= lo) && (p.s < hi);
        n.div_x.rem = (tdp_pkg::ColW+1)'((p.s >= p.lc) ? p.s - p.lc : p.lc - p.s);
        n.den_x     = (tdp_pkg::ColW+1)'((p.sc >= p.lc) ? p.sc - p.lc : p.lc - p.sc);
        n.div_x.q   = '0;
        n.sat = n.div_x.rem >= n.den_x;
        ddl  = (tdp_pkg::DepthW+1)'(p.bot.d) - (tdp_pkg::DepthW+1)'(p.top.d);
        dds  = (tdp_pkg::DepthW+1)'(p.sb.d) - (tdp_pkg::DepthW+1)'(p.st.d);
        pl   = ddl * signed'({2'b00, p.div_l.q});
        ps   = dds * signed'({2'b00, p.div_s.q});
        n.dl = tdp_pkg::DepthW'((pl >>> tdp_pkg::FracB) + tdp_pkg::ProdW'(p.top.d));
        n.ds = tdp_pkg::DepthW'((ps >>> tdp_pkg::FracB) + tdp_pkg::ProdW'(p.st.d));
      end else if (k < MulSt) begin
        // Span fraction; a saturated one skips the division result below.
        n.div_x = tdp_pkg::div_step(p.div_x, p.den_x);
      end else if (k == MulSt) begin
        ddx    = (tdp_pkg::DepthW+1)'(p.ds) - (tdp_pkg::DepthW+1)'(p.dl);
        fx     = p.sat ? tdp_pkg::FracOne : {1'b0, p.div_x.q};
        n.prod = ddx * signed'({1'b0, fx});
      end else begin
        // Output register: long-edge depth plus the floored span product, or the far depth if uncovered.
        sum  = (p.prod >>> tdp_pkg::FracB) + tdp_pkg::ProdW'(p.dl);
        n.dl = p.cov ? tdp_pkg::DepthW'(sum) : tdp_pkg::DepthFar;
      end
      pipe_next[k] = n;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NumSt; k++) begin
      if (rst) begin
        pipe[k].v <= 1'b0;
      end else if (adv) begin
        pipe[k] <= pipe_next[k];
      end
    end
  end

  assign rsp.valid       = pipe[OutSt].v;
  assign rsp.covered     = pipe[OutSt].cov;
  assign rsp.point_depth = pipe[OutSt].dl;

  // An uncovered word always reports the far depth.
  a_far_depth: assert property (@(posedge clk) disable iff (rst)
    pipe[OutSt].v && !pipe[OutSt].cov |-> pipe[OutSt].dl == tdp_pkg::DepthFar)
    else $error("uncovered word without far depth");

  // Inside the span the distance to the long edge never exceeds the span width.
  a_span_sat: assert property (@(posedge clk) disable iff (rst)
    pipe[SpanSt].v && pipe[SpanSt].cov && pipe[SpanSt].sat
      |-> pipe[SpanSt].div_x.rem == pipe[SpanSt].den_x)
    else $error("span fraction above one");

  // A word taken at the input enters the first stage.
  a_enter: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> pipe[0].v)
    else $error("accepted word not in first stage");

  // A held pipe keeps the last stage's occupancy.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> pipe[OutSt].v)
    else $error("stalled output word lost");

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the triangle depth pipeline: random and directed words.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // One request word as it is sent to the block.
  typedef struct {
    logic signed [tdp_pkg::CoordW-1:0] ar, ac, br, bc, cr, cc, sr, sc;
    logic signed [tdp_pkg::DepthW-1:0] ad, bd, cd;
  } query_t;

  // One expected response word.
  typedef struct {
    logic                              covered;
    logic signed [tdp_pkg::DepthW-1:0] depth;
  } answer_t;

  localparam longint FOne = 64'sd1 << tdp_pkg::FracB;
  localparam int MaxCycles = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tdp_in_if  req ();
  tdp_out_if rsp ();

  triangle_depth_at_point u_top (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  always #10 clk = ~clk;

  query_t  pending_queries[$];
  answer_t expected_answers[$];
  int      mismatches = 0;
  int      cycle_count = 0;
  // Idle control, shared between the stimulus and the two sides.
  bit      no_idle = 1'b0;
  bit      sender_hold = 1'b0;
  int      receiver_hold_cycles = 0;

  // floor(num * 2^FracB / den), saturated at one.
  function automatic longint edge_fraction(longint num, longint den);
    longint q;
    longint r;
    if (den == 0 || num >= den) return FOne;
    q = 0;
    r = num;
    for (int i = 0; i < tdp_pkg::FracB; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 64'sd1;
      end
    end
    return q;
  endfunction

  // floor(d * f / 2^FracB); the magnitude is split so nothing overflows 64 bits.
  function automatic longint scale_floor(longint d, longint f);
    longint m;
    longint lo;
    longint q;
    m  = (d < 0) ? -d : d;
    lo = (m & (FOne - 1)) * f;
    q  = (m >> tdp_pkg::FracB) * f + (lo >> tdp_pkg::FracB);
    if (d < 0) begin
      if ((lo & (FOne - 1)) != 0) q = q + 1;
      return -q;
    end
    return q;
  endfunction

  function automatic answer_t depth_at_point(query_t x);
    answer_t a;
    longint tr, tc, td, mr, mc, md, br, bc, bd;
    longint ur, uc, ud, vr, vc, vd;
    longint row, col, al, as, ald, lc, scol, s, lo, hi, dl, ds;
    longint ar_, ac_, ad_, br_, bc_, bd_, cr_, cc_, cd_;
    a.covered = 1'b0;
    a.depth   = tdp_pkg::DepthFar;
    ar_ = longint'(x.ar); ac_ = longint'(x.ac); ad_ = longint'(x.ad);
    br_ = longint'(x.br); bc_ = longint'(x.bc); bd_ = longint'(x.bd);
    cr_ = longint'(x.cr); cc_ = longint'(x.cc); cd_ = longint'(x.cd);
    // Sort by row using only "less or equal", so ties keep the order a, b, c.
    if (ar_ <= br_) begin
      if (br_ <= cr_) begin
        tr = ar_; tc = ac_; td = ad_; mr = br_; mc = bc_; md = bd_;
        br = cr_; bc = cc_; bd = cd_;
      end else if (ar_ <= cr_) begin
        tr = ar_; tc = ac_; td = ad_; mr = cr_; mc = cc_; md = cd_;
        br = br_; bc = bc_; bd = bd_;
      end else begin
        tr = cr_; tc = cc_; td = cd_; mr = ar_; mc = ac_; md = ad_;
        br = br_; bc = bc_; bd = bd_;
      end
    end else if (ar_ <= cr_) begin
      tr = br_; tc = bc_; td = bd_; mr = ar_; mc = ac_; md = ad_;
      br = cr_; bc = cc_; bd = cd_;
    end else if (br_ <= cr_) begin
      tr = br_; tc = bc_; td = bd_; mr = cr_; mc = cc_; md = cd_;
      br = ar_; bc = ac_; bd = ad_;
    end else begin
      tr = cr_; tc = cc_; td = cd_; mr = br_; mc = bc_; md = bd_;
      br = ar_; bc = ac_; bd = ad_;
    end
    row = longint'(x.sr);
    col = longint'(x.sc);
    if (row < tr || row >= br) return a;
    // The upper short edge only applies strictly above the middle vertex.
    if (row < mr) begin
      ur = tr; uc = tc; ud = td; vr = mr; vc = mc; vd = md;
    end else begin
      ur = mr; uc = mc; ud = md; vr = br; vc = bc; vd = bd;
    end
    al   = edge_fraction(row - tr, br - tr);
    as   = edge_fraction(row - ur, vr - ur);
    lc   = tc * FOne + (bc - tc) * al;
    scol = uc * FOne + (vc - uc) * as;
    s    = col * FOne;
    lo   = (lc <= scol) ? lc : scol;
    hi   = (lc <= scol) ? scol : lc;
    if (s >= lo && s < hi) begin
      ald = edge_fraction((s >= lc) ? s - lc : lc - s, (scol >= lc) ? scol - lc : lc - scol);
      dl  = td + scale_floor(bd - td, al);
      ds  = ud + scale_floor(vd - ud, as);
      a.covered = 1'b1;
      a.depth   = tdp_pkg::DepthW'(dl + scale_floor(ds - dl, ald));
    end
    return a;
  endfunction

  function automatic query_t random_query();
    query_t q;
    q.ar = tdp_pkg::CoordW'($urandom); q.ac = tdp_pkg::CoordW'($urandom); q.ad = $urandom;
    q.br = tdp_pkg::CoordW'($urandom); q.bc = tdp_pkg::CoordW'($urandom); q.bd = $urandom;
    q.cr = tdp_pkg::CoordW'($urandom); q.cc = tdp_pkg::CoordW'($urandom); q.cd = $urandom;
    q.sr = tdp_pkg::CoordW'($urandom); q.sc = tdp_pkg::CoordW'($urandom);
    return q;
  endfunction

  // A triangle of modest size with the sample point placed near or inside it,
  // so most words exercise the covered path.
  function automatic query_t near_query();
    query_t q;
    int cr;
    int cc;
    int span;
    span = ($urandom_range(0, 3) == 0) ? 30000 : int'($urandom_range(4, 800));
    cr = int'($urandom_range(0, 40000)) - 20000;
    cc = int'($urandom_range(0, 40000)) - 20000;
    q = random_query();
    q.ar = tdp_pkg::CoordW'(cr + int'($urandom_range(0, 2 * span)) - span);
    q.br = tdp_pkg::CoordW'(cr + int'($urandom_range(0, 2 * span)) - span);
    q.cr = ($urandom_range(0, 5) == 0) ? q.ar
         : tdp_pkg::CoordW'(cr + int'($urandom_range(0, 2 * span)) - span);
    q.ac = tdp_pkg::CoordW'(cc + int'($urandom_range(0, 2 * span)) - span);
    q.bc = tdp_pkg::CoordW'(cc + int'($urandom_range(0, 2 * span)) - span);
    q.cc = tdp_pkg::CoordW'(cc + int'($urandom_range(0, 2 * span)) - span);
    q.sr = tdp_pkg::CoordW'(cr + int'($urandom_range(0, span)) - span / 2);
    q.sc = tdp_pkg::CoordW'(cc + int'($urandom_range(0, span)) - span / 2);
    return q;
  endfunction

  function automatic query_t make_query(int ar, int ac, int ad, int br, int bc, int bd,
                                        int cr, int cc, int cd, int sr, int sc);
    query_t q;
    q.ar = tdp_pkg::CoordW'(ar); q.ac = tdp_pkg::CoordW'(ac); q.ad = ad;
    q.br = tdp_pkg::CoordW'(br); q.bc = tdp_pkg::CoordW'(bc); q.bd = bd;
    q.cr = tdp_pkg::CoordW'(cr); q.cc = tdp_pkg::CoordW'(cc); q.cd = cd;
    q.sr = tdp_pkg::CoordW'(sr); q.sc = tdp_pkg::CoordW'(sc);
    return q;
  endfunction

  // Driver: presents the head of the queue and pops it once the word is taken.
  always @(posedge clk) begin
    if (rst) begin
      req.valid          <= 1'b0;
      req.vertex_a_row   <= '0;
      req.vertex_a_col   <= '0;
      req.vertex_a_depth <= '0;
      req.vertex_b_row   <= '0;
      req.vertex_b_col   <= '0;
      req.vertex_b_depth <= '0;
      req.vertex_c_row   <= '0;
      req.vertex_c_col   <= '0;
      req.vertex_c_depth <= '0;
      req.sample_row     <= '0;
      req.sample_col     <= '0;
    end else begin
      if (req.valid && req.ready) begin
        expected_answers.push_back(depth_at_point(pending_queries.pop_front()));
      end
      // Decide the next cycle from what remains after any pop above.
      if ((req.valid && !req.ready) ||
          (pending_queries.size() > 0 && !sender_hold &&
           (no_idle || $urandom_range(0, 99) >= 7))) begin
        req.valid          <= 1'b1;
        req.vertex_a_row   <= pending_queries[0].ar;
        req.vertex_a_col   <= pending_queries[0].ac;
        req.vertex_a_depth <= pending_queries[0].ad;
        req.vertex_b_row   <= pending_queries[0].br;
        req.vertex_b_col   <= pending_queries[0].bc;
        req.vertex_b_depth <= pending_queries[0].bd;
        req.vertex_c_row   <= pending_queries[0].cr;
        req.vertex_c_col   <= pending_queries[0].cc;
        req.vertex_c_depth <= pending_queries[0].cd;
        req.sample_row     <= pending_queries[0].sr;
        req.sample_col     <= pending_queries[0].sc;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // Monitor and receiver: checks each accepted response word, then chooses ready.
  always @(posedge clk) begin
    answer_t e;
    cycle_count <= cycle_count + 1;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_answers.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) $display("unexpected response word at cycle %0d", cycle_count);
        end else begin
          e = expected_answers.pop_front();
          if (rsp.covered !== e.covered || rsp.point_depth !== e.depth) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display("mismatch: expected covered=%0b depth=%0d, got covered=%0b depth=%0d",
                       e.covered, e.depth, rsp.covered, rsp.point_depth);
          end
        end
      end
      if (receiver_hold_cycles > 0) begin
        receiver_hold_cycles <= receiver_hold_cycles - 1;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= no_idle || ($urandom_range(0, 99) >= 7);
      end
    end
  end

  // Timeout watch.
  always @(posedge clk) begin
    if (cycle_count > MaxCycles) begin
      $display("triangle_depth_at_point verification failed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed words: extremes of the vertex fields, flat tops and bottoms, row ties,
    // points on the left and right span edges, rows above and at the bottom.
    pending_queries.push_back(make_query(0, 0, 0, 160, 0, 65536, 160, 160, 131072, 32, 16));
    pending_queries.push_back(make_query(0, 0, 100, 0, 160, 200, 160, 0, 300, 0, 0));
    pending_queries.push_back(make_query(0, 0, 100, 0, 160, 200, 160, 0, 300, 0, 160));
    pending_queries.push_back(make_query(0, 80, 5, 160, 0, 6, 160, 160, 7, 159, 0));
    pending_queries.push_back(make_query(0, 80, 5, 160, 0, 6, 160, 160, 7, 160, 80));
    pending_queries.push_back(make_query(0, 80, 5, 160, 0, 6, 160, 160, 7, -1, 80));
    pending_queries.push_back(make_query(160, 0, 9, 0, 0, 8, 80, 160, 7, 80, 159));
    pending_queries.push_back(make_query(80, 0, 1, 80, 80, 2, 80, 160, 3, 80, 40));
    pending_queries.push_back(make_query(-32768, -32768, 32'h8000_0000, 32767, 32767,
                                         32'h7fff_ffff, 32767, -32768, 32'h8000_0000,
                                         0, 0));
    pending_queries.push_back(make_query(-32768, 32767, 32'h7fff_ffff, 32767, -32768,
                                         32'h8000_0000, -32768, -32768, 32'h7fff_ffff,
                                         -32768, -32768));
    pending_queries.push_back(make_query(-32768, 32767, 32'h8000_0000, 32767, 32767,
                                         32'h7fff_ffff, 0, -32768, 0, 32766, 32766));
    pending_queries.push_back(make_query(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
    pending_queries.push_back(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_queries.push_back(make_query(32767, 0, 0, 32767, 5, 0, 32767, 9, 0, 32767, 3));
    pending_queries.push_back(make_query(16, 16, -65536, 48, 0, 65536, 48, 32, 0, 47, 31));
    pending_queries.push_back(make_query(10, 0, 1000, 20, 100, -1000, 5, 50, 0, 10, 20));
    wait (pending_queries.size() == 0);

    // Sender pause until everything has drained.
    sender_hold = 1'b1;
    wait (expected_answers.size() == 0);
    sender_hold = 1'b0;

    // Receiver stall while the sender keeps offering, so the pipeline backs up.
    no_idle = 1'b1;
    for (int i = 0; i < 60; i++) pending_queries.push_back(near_query());
    receiver_hold_cycles = 80;
    wait (pending_queries.size() == 0);

    // Stretch with no idling on either side.
    for (int i = 0; i < 80; i++)
      pending_queries.push_back(($urandom_range(0, 4) == 0) ? random_query() : near_query());
    wait (pending_queries.size() == 0);
    no_idle = 1'b0;

    // Random idling on both sides.
    for (int i = 0; i < 240; i++)
      pending_queries.push_back(($urandom_range(0, 4) == 0) ? random_query() : near_query());
    wait (pending_queries.size() == 0);

    wait (expected_answers.size() == 0);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("triangle_depth_at_point verification clean");
    end else begin
      $display("triangle_depth_at_point verification failed");
    end
    $finish;
  end
endmodule
